// ===== hw/rtl/loc_pkg.sv =====
// shared types, constants and helpers for the lock-order checker
// used by loc_ctrl, loc_dp and lock_order_cycle_checker; no dependencies
package loc_pkg;

  localparam int LOCK_COUNT   = 64;
  localparam int THREAD_COUNT = 8;
  localparam int LOCK_W       = $clog2(LOCK_COUNT);
  localparam int THREAD_W     = $clog2(THREAD_COUNT);

  // event kinds
  localparam logic [1:0] KIND_WILL_LOCK = 2'd0;
  localparam logic [1:0] KIND_LOCKED    = 2'd1;
  localparam logic [1:0] KIND_UNLOCK    = 2'd2;
  localparam logic [1:0] KIND_UNREG     = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_REC   = 2'd1;
  localparam logic [1:0] STAT_CYCLE = 2'd2;

  // register indexes
  localparam logic REG_ENABLE = 1'b0;

  typedef logic [3:0] cmd_t;

  // datapath commands
  localparam cmd_t CMD_NONE      = 4'd0;
  localparam cmd_t CMD_LOAD      = 4'd1;
  localparam cmd_t CMD_HELD_SET  = 4'd2;
  localparam cmd_t CMD_HELD_CLR  = 4'd3;
  localparam cmd_t CMD_PICK_HELD = 4'd4;
  localparam cmd_t CMD_RD_START  = 4'd5;
  localparam cmd_t CMD_FR_LOAD   = 4'd6;
  localparam cmd_t CMD_PICK_FR   = 4'd7;
  localparam cmd_t CMD_FR_MERGE  = 4'd8;
  localparam cmd_t CMD_EDGE_WR   = 4'd9;
  localparam cmd_t CMD_ERR_REC   = 4'd10;
  localparam cmd_t CMD_ERR_CYC   = 4'd11;
  localparam cmd_t CMD_ROW_CLR   = 4'd12;
  localparam cmd_t CMD_SWEEP_RD  = 4'd13;
  localparam cmd_t CMD_SWEEP_WR  = 4'd14;
  localparam cmd_t CMD_PUSH      = 4'd15;

  typedef struct packed {
    logic       walk_empty;
    logic       h_is_id;
    logic       rd_hit_id;
    logic       fr_hit;
    logic       fr_empty;
    logic       sweep_last;
    logic       out_busy;
    logic [1:0] kind;
    logic       rec;
  } dp_stat_t;

  // index of the lowest set bit, zero when none
  function automatic logic [LOCK_W-1:0] lowest_idx(input logic [LOCK_COUNT-1:0] v);
    logic [LOCK_W-1:0] idx;
    idx = '0;
    for (int i = LOCK_COUNT - 1; i >= 0; i--) begin
      if (v[i]) idx = LOCK_W'(i);
    end
    return idx;
  endfunction

endpackage

// ===== hw/rtl/loc_dp.sv =====
// datapath: dependency matrix memory, held sets, walk and frontier sets, result register
// depends on loc_pkg
module loc_dp import loc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  input  logic [1:0]          in_kind,
  input  logic [THREAD_W-1:0] in_thr,
  input  logic [LOCK_W-1:0]   in_lock,
  input  logic                in_rec,
  output dp_stat_t            stat,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,   // [5:0] culprit_lock, [7:6] zero
  output logic [1:0]          out_tuser    // [1:0] status
);

  logic [1:0]            kind_r;
  logic [THREAD_W-1:0]   thr_r;
  logic [LOCK_W-1:0]     id_r;
  logic                  rec_r;
  logic [LOCK_W-1:0]     h_r;
  logic [LOCK_COUNT-1:0] walk_r;
  logic [LOCK_COUNT-1:0] fr_r;
  logic [LOCK_COUNT-1:0] vis_r;
  logic [LOCK_COUNT-1:0] hrow_r;
  logic [LOCK_COUNT-1:0] held_r [THREAD_COUNT];
  logic [LOCK_COUNT-1:0] row_vld_r;
  logic [LOCK_COUNT-1:0] mem [LOCK_COUNT];
  logic [LOCK_COUNT-1:0] rd_q_r;
  logic                  rd_vld_r;
  logic [LOCK_W-1:0]     sw_r;
  logic [1:0]            res_st_r;
  logic [LOCK_W-1:0]     res_cul_r;
  logic                  ov_r;
  logic [1:0]            out_st_r;
  logic [LOCK_W-1:0]     out_cul_r;

  logic [LOCK_COUNT-1:0] rd_row;
  logic [LOCK_COUNT-1:0] id_bit;
  logic [LOCK_W-1:0]     walk_lo;
  logic [LOCK_W-1:0]     fr_lo;
  logic                  rd_en;
  logic [LOCK_W-1:0]     rd_addr;
  logic                  wr_en;
  logic [LOCK_W-1:0]     wr_addr;
  logic [LOCK_COUNT-1:0] wr_data;

  assign rd_row  = rd_vld_r ? rd_q_r : '0;
  assign id_bit  = LOCK_COUNT'(1) << id_r;
  assign walk_lo = lowest_idx(walk_r);
  assign fr_lo   = lowest_idx(fr_r);

  // memory port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = id_r;
    wr_en   = 1'b0;
    wr_addr = h_r;
    wr_data = hrow_r | id_bit;
    case (cmd)
      CMD_PICK_HELD: begin rd_en = 1'b1; rd_addr = walk_lo; end
      CMD_RD_START:  begin rd_en = 1'b1; rd_addr = id_r; end
      CMD_PICK_FR:   begin rd_en = 1'b1; rd_addr = fr_lo; end
      CMD_SWEEP_RD:  begin rd_en = 1'b1; rd_addr = sw_r; end
      CMD_EDGE_WR:   begin wr_en = 1'b1; end
      CMD_SWEEP_WR:  begin
        wr_en   = 1'b1;
        wr_addr = sw_r;
        wr_data = rd_row & ~id_bit;
      end
      default: ;
    endcase
  end

  // dependency matrix rows
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q_r <= mem[rd_addr];
  end

  // row valid bits, read valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (rd_en) rd_vld_r <= row_vld_r[rd_addr];
      if (wr_en) row_vld_r[wr_addr] <= 1'b1;
      else if (cmd == CMD_ROW_CLR) row_vld_r[id_r] <= 1'b0;
    end
  end

  // held sets
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int t = 0; t < THREAD_COUNT; t++) held_r[t] <= '0;
    end else if (cmd == CMD_HELD_SET) begin
      held_r[thr_r] <= held_r[thr_r] | id_bit;
    end else if (cmd == CMD_HELD_CLR) begin
      held_r[thr_r] <= held_r[thr_r] & ~id_bit;
    end
  end

  // event fields, walk and frontier state
  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        kind_r    <= in_kind;
        thr_r     <= in_thr;
        id_r      <= in_lock;
        rec_r     <= in_rec;
        walk_r    <= held_r[in_thr];
        sw_r      <= '0;
        res_st_r  <= STAT_OK;
        res_cul_r <= '0;
      end
      CMD_PICK_HELD: begin
        h_r    <= walk_lo;
        walk_r <= walk_r & ~(LOCK_COUNT'(1) << walk_lo);
      end
      CMD_RD_START: hrow_r <= rd_row;
      CMD_FR_LOAD: begin
        fr_r  <= rd_row;
        vis_r <= '0;
      end
      CMD_PICK_FR: begin
        vis_r <= vis_r | (LOCK_COUNT'(1) << fr_lo);
        fr_r  <= fr_r & ~(LOCK_COUNT'(1) << fr_lo);
      end
      CMD_FR_MERGE: fr_r <= fr_r | (rd_row & ~vis_r);
      CMD_ERR_REC: begin
        res_st_r  <= STAT_REC;
        res_cul_r <= h_r;
      end
      CMD_ERR_CYC: begin
        res_st_r  <= STAT_CYCLE;
        res_cul_r <= h_r;
      end
      CMD_SWEEP_WR: sw_r <= sw_r + 1'b1;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd == CMD_PUSH) begin
      ov_r <= 1'b1;
    end else if (out_tready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_PUSH) begin
      out_st_r  <= res_st_r;
      out_cul_r <= res_cul_r;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = 8'(out_cul_r);
  assign out_tuser  = out_st_r;

  // status to the controller
  assign stat.walk_empty = (walk_r == '0);
  assign stat.h_is_id    = (h_r == id_r);
  assign stat.rd_hit_id  = rd_row[id_r];
  assign stat.fr_hit     = fr_r[h_r];
  assign stat.fr_empty   = (fr_r == '0);
  assign stat.sweep_last = (sw_r == LOCK_W'(LOCK_COUNT - 1));
  assign stat.out_busy   = ov_r & ~out_tready;
  assign stat.kind       = kind_r;
  assign stat.rec        = rec_r;

`ifndef ASSERT_OFF
  a_pick_held_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd == CMD_PICK_HELD |-> walk_r != '0) else $error("held pick from empty set");
  a_pick_fr_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd == CMD_PICK_FR |-> fr_r != '0) else $error("frontier pick from empty set");
  a_edge_not_self: assert property (@(posedge clk) disable iff (!rst_n)
    cmd == CMD_EDGE_WR |-> h_r != id_r) else $error("self edge recorded");
  a_push_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd == CMD_PUSH |-> !(ov_r && !out_tready)) else $error("result overwritten");
`endif

endmodule

// ===== hw/rtl/loc_ctrl.sv =====
// controller state machine sequencing the held walk, reachability walk and column sweep
// depends on loc_pkg
module loc_ctrl import loc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     enable,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  dp_stat_t stat,
  output cmd_t     cmd
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DECODE = 4'd1;
  localparam logic [3:0] ST_PICK   = 4'd2;
  localparam logic [3:0] ST_CHK    = 4'd3;
  localparam logic [3:0] ST_FRLOAD = 4'd4;
  localparam logic [3:0] ST_WALK   = 4'd5;
  localparam logic [3:0] ST_MERGE  = 4'd6;
  localparam logic [3:0] ST_SW_RD  = 4'd7;
  localparam logic [3:0] ST_SW_WR  = 4'd8;
  localparam logic [3:0] ST_DONE   = 4'd9;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  // next state and command
  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd       = CMD_LOAD;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (!enable) begin
          state_nxt = ST_DONE;
        end else begin
          case (stat.kind)
            KIND_WILL_LOCK: state_nxt = ST_PICK;
            KIND_LOCKED: begin
              cmd       = CMD_HELD_SET;
              state_nxt = ST_DONE;
            end
            KIND_UNLOCK: begin
              cmd       = CMD_HELD_CLR;
              state_nxt = ST_DONE;
            end
            default: begin
              cmd       = CMD_ROW_CLR;
              state_nxt = ST_SW_RD;
            end
          endcase
        end
      end
      ST_PICK: begin
        if (stat.walk_empty) begin
          state_nxt = ST_DONE;
        end else begin
          cmd       = CMD_PICK_HELD;
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        if (stat.h_is_id) begin
          if (stat.rec) begin
            state_nxt = ST_PICK;
          end else begin
            cmd       = CMD_ERR_REC;
            state_nxt = ST_DONE;
          end
        end else if (stat.rd_hit_id) begin
          state_nxt = ST_PICK;
        end else begin
          cmd       = CMD_RD_START;
          state_nxt = ST_FRLOAD;
        end
      end
      ST_FRLOAD: begin
        cmd       = CMD_FR_LOAD;
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (stat.fr_hit) begin
          cmd       = CMD_ERR_CYC;
          state_nxt = ST_DONE;
        end else if (stat.fr_empty) begin
          cmd       = CMD_EDGE_WR;
          state_nxt = ST_PICK;
        end else begin
          cmd       = CMD_PICK_FR;
          state_nxt = ST_MERGE;
        end
      end
      ST_MERGE: begin
        cmd       = CMD_FR_MERGE;
        state_nxt = ST_WALK;
      end
      ST_SW_RD: begin
        cmd       = CMD_SWEEP_RD;
        state_nxt = ST_SW_WR;
      end
      ST_SW_WR: begin
        cmd       = CMD_SWEEP_WR;
        state_nxt = stat.sweep_last ? ST_DONE : ST_SW_RD;
      end
      ST_DONE: begin
        if (!stat.out_busy) begin
          cmd       = CMD_PUSH;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == ST_DECODE) else $error("accept without decode");
  a_sweep_pairs: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SW_RD |=> state_r == ST_SW_WR) else $error("sweep read without write");
  a_merge_follows_pick: assert property (@(posedge clk) disable iff (!rst_n)
    cmd == CMD_PICK_FR |=> cmd == CMD_FR_MERGE) else $error("frontier pick not merged");
`endif

endmodule

// ===== hw/rtl/lock_order_cycle_checker.sv =====
// lock-order checker: one result beat per input beat; disabled or simple events need no walk,
// unregister sweeps the matrix column with one read and one write per matrix row,
// will_lock walks each held lock and the rows reached from it, reading one row at a time
// through the single read port of the dependency matrix memory; one event at a time
// synchronous active-low reset clears held sets, matrix row valid bits and the enable register
// depends on loc_pkg, loc_ctrl and loc_dp
module lock_order_cycle_checker import loc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [2:0] thread_index, [8:3] lock_index, [15:9] zero
  input  logic [2:0]  in_tuser,   // [1:0] kind, [2] recursion_allowed
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [5:0] culprit_lock, [7:6] zero
  output logic [1:0]  out_tuser,  // [1:0] status
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic     enable_r;
  logic     cfg_sel0;
  cmd_t     cmd;
  dp_stat_t stat;

  // configuration register
  assign cfg_pready = 1'b1;
  assign cfg_sel0   = (cfg_paddr[2] == REG_ENABLE) && (cfg_paddr[1:0] == 2'b00);
  assign cfg_prdata = cfg_sel0 ? {31'b0, enable_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_sel0) begin
      enable_r <= cfg_pwdata[0];
    end
  end

  loc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .enable    (enable_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  loc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_kind    (in_tuser[1:0]),
    .in_thr     (in_tdata[2:0]),
    .in_lock    (in_tdata[8:3]),
    .in_rec     (in_tuser[2]),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
